>>> design/hv2c_pkg.sv
// Package for the two-objective hypervolume block.
// Holds the channel payload types, controller states and control structs.
// No dependencies.
`timescale 1ns / 1ps

package hv2c_pkg;

  localparam int AREA_W = 36;
  localparam int TAG_W  = 6;
  localparam int FIELD_W = 16;

  // Result kinds
  localparam logic KIND_TOTAL   = 1'b0;
  localparam logic KIND_CONTRIB = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] objective_a;
    logic [FIELD_W-1:0] objective_b;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic                     result_kind;
    logic [TAG_W-1:0]         point_tag;
    logic signed [AREA_W-1:0] area_value;
    logic                     final_result;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_LOAD    = 5'b00001,
    ST_PREP    = 5'b00010,
    ST_SWEEP   = 5'b00100,
    ST_TOTAL   = 5'b01000,
    ST_CONTRIB = 5'b10000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic sweep;
    logic emit_total;
    logic emit_contrib;
    logic clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic k_last;
    logic out_free;
  } sts_t;

endpackage

>>> design/hv2c_ctrl.sv
// Controller for the hypervolume block: load, sweep and emission sequencing.
// Depends on hv2c_pkg.
`timescale 1ns / 1ps

module hv2c_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  hv2c_pkg::sts_t sts,
  output hv2c_pkg::cmd_t cmd
);
  import hv2c_pkg::*;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.cnt_zero ? ST_TOTAL : ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.k_last) begin
          state_nxt = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        if (sts.out_free) begin
          cmd.emit_total = 1'b1;
          if (sts.cnt_zero) begin
            cmd.clear = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_CONTRIB;
          end
        end
      end
      ST_CONTRIB: begin
        if (sts.out_free) begin
          cmd.emit_contrib = 1'b1;
          if (sts.k_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/hv2c_datapath.sv
// Datapath: sorted point row, maxima, reference point, strip multiplier,
// accumulator, configuration register and result register.
// Depends on hv2c_pkg.
`timescale 1ns / 1ps

module hv2c_datapath #(
  parameter int MAX_POINTS = 32,
  parameter int OBJ_WIDTH  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hv2c_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  input  hv2c_pkg::cmd_t      cmd,
  output hv2c_pkg::sts_t      sts,
  input  logic                out_ready,
  output logic                out_valid,
  output hv2c_pkg::out_item_t out_data
);
  import hv2c_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = ((OBJ_WIDTH > FIELD_W) ? OBJ_WIDTH : FIELD_W) + 1;
  localparam int PW = 2 * (RW + 1);
  localparam int NB = (MAX_POINTS > 1) ? 1 : 0;

  // Sorted row, descending by second objective, stable
  logic [OBJ_WIDTH-1:0] a_r [MAX_POINTS];
  logic [OBJ_WIDTH-1:0] b_r [MAX_POINTS];
  logic [TAG_W-1:0]     tag_r [MAX_POINTS];
  logic [OBJ_WIDTH-1:0] a_nxt [MAX_POINTS];
  logic [OBJ_WIDTH-1:0] b_nxt [MAX_POINTS];
  logic [TAG_W-1:0]     tag_nxt [MAX_POINTS];

  logic [CW-1:0]        cnt_r, k_r;
  logic [OBJ_WIDTH-1:0] max_a_r, max_b_r;
  logic [15:0]          off_r;
  logic [RW-1:0]        r0_r, r1_r, prevb_r;
  logic [AREA_W-1:0]    acc_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [OBJ_WIDTH-1:0] a_in, b_in;
  logic [MAX_POINTS-1:0] ge;
  logic                 full, k_last, step, out_load;
  logic [CW-1:0]        last_pos;
  logic signed [RW:0]   op_a, op_b;
  logic signed [PW-1:0] prod;
  logic [AREA_W-1:0]    term;

  assign a_in     = OBJ_WIDTH'(in_data.objective_a);
  assign b_in     = OBJ_WIDTH'(in_data.objective_b);
  assign full     = (cnt_r == CW'(MAX_POINTS));
  assign last_pos = cnt_r - 1'b1;
  assign k_last   = (k_r == last_pos);
  assign step     = cmd.sweep | cmd.emit_contrib;
  assign out_load = cmd.emit_total | cmd.emit_contrib;

  // Insertion compare: held entries not below the new point stay ahead of it
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      ge[i] = (CW'(i) < cnt_r) && (b_r[i] >= b_in);
    end
  end

  // Row update: insert on load, rotate over the held entries when stepping
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      a_nxt[i]   = a_r[i];
      b_nxt[i]   = b_r[i];
      tag_nxt[i] = tag_r[i];
      if (cmd.load && !full) begin
        if (!ge[i]) begin
          if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
            a_nxt[i]   = a_in;
            b_nxt[i]   = b_in;
            tag_nxt[i] = TAG_W'(cnt_r);
          end else begin
            a_nxt[i]   = a_r[(i == 0) ? 0 : i - 1];
            b_nxt[i]   = b_r[(i == 0) ? 0 : i - 1];
            tag_nxt[i] = tag_r[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (step) begin
        if (CW'(i) == last_pos || i == MAX_POINTS - 1) begin
          a_nxt[i]   = a_r[0];
          b_nxt[i]   = b_r[0];
          tag_nxt[i] = tag_r[0];
        end else begin
          a_nxt[i]   = a_r[(i == MAX_POINTS - 1) ? 0 : i + 1];
          b_nxt[i]   = b_r[(i == MAX_POINTS - 1) ? 0 : i + 1];
          tag_nxt[i] = tag_r[(i == MAX_POINTS - 1) ? 0 : i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      a_r[i]   <= a_nxt[i];
      b_r[i]   <= b_nxt[i];
      tag_r[i] <= tag_nxt[i];
    end
  end

  // Strip multiplier: width term in the sweep and for the last point,
  // first-objective difference to the next point otherwise
  always_comb begin
    if (cmd.emit_contrib && !k_last) begin
      op_a = $signed({1'b0, RW'(a_r[NB])}) - $signed({1'b0, RW'(a_r[0])});
    end else begin
      op_a = $signed({1'b0, r0_r - RW'(a_r[0])});
    end
    op_b = $signed({1'b0, prevb_r - RW'(b_r[0])});
    prod = op_a * op_b;
    term = AREA_W'(prod);
  end

  // Control and arithmetic registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      k_r         <= '0;
      max_a_r     <= '0;
      max_b_r     <= '0;
      off_r       <= 16'd1;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        off_r <= cfg_data;
      end
      if (cmd.clear) begin
        cnt_r   <= '0;
        max_a_r <= '0;
        max_b_r <= '0;
      end else if (cmd.load && !full) begin
        cnt_r <= cnt_r + 1'b1;
        if (a_in > max_a_r) begin
          max_a_r <= a_in;
        end
        if (b_in > max_b_r) begin
          max_b_r <= b_in;
        end
      end
      if (cmd.prep) begin
        acc_r <= '0;
        k_r   <= '0;
      end else if (cmd.sweep) begin
        acc_r <= acc_r + term;
        k_r   <= k_r + 1'b1;
      end else if (cmd.emit_total) begin
        k_r <= '0;
      end else if (cmd.emit_contrib) begin
        k_r <= k_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Reference point, previous strip edge and result payload
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      r0_r    <= RW'(max_a_r) + RW'(off_r);
      r1_r    <= RW'(max_b_r) + RW'(off_r);
      prevb_r <= RW'(max_b_r) + RW'(off_r);
    end else if (cmd.emit_total) begin
      prevb_r <= r1_r;
    end else if (step) begin
      prevb_r <= RW'(b_r[0]);
    end
    if (cmd.emit_total) begin
      out_data_r.result_kind  <= KIND_TOTAL;
      out_data_r.point_tag    <= '0;
      out_data_r.area_value   <= acc_r;
      out_data_r.final_result <= (cnt_r == '0);
    end else if (cmd.emit_contrib) begin
      out_data_r.result_kind  <= KIND_CONTRIB;
      out_data_r.point_tag    <= tag_r[0];
      out_data_r.area_value   <= term;
      out_data_r.final_result <= k_last;
    end
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.k_last   = k_last;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

>>> design/hypervolume_2d_contributions_core.sv
// Two-objective hypervolume and per-point contribution engine, top level.
// Instantiates hv2c_ctrl and hv2c_datapath; depends on hv2c_pkg.
//
// Usage:
//   in_*  : one point per transfer; last_point closes the set and starts work.
//           Points load at one per cycle into a row kept sorted on arrival.
//   out_* : first the total hypervolume, then one contribution per point in
//           descending second-objective order, tagged with arrival index;
//           final_result marks the last result of the run.
//   cfg_* : ref_offset write, always ready; write only while idle.
//   Sequence: after the closing transfer, a set-up step, a sweep of the strip
//   multiplier-accumulator over the sorted row, then n + 1 results at one per
//   cycle while out_ready is held; the pace is set by the single shared
//   multiplier stepping through the sorted row.
//   in_ready stays low from the closing transfer until the last result has
//   entered the output register. A stalled receiver holds the output
//   register and pauses the emission.
//   Points beyond MAX_POINTS are dropped. Reset empties the set, clears the
//   maxima and sets ref_offset to 1.
`timescale 1ns / 1ps

module hypervolume_2d_contributions_core #(
  parameter int MAX_POINTS = 32,
  parameter int OBJ_WIDTH  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hv2c_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hv2c_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import hv2c_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  hv2c_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_point),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hv2c_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .OBJ_WIDTH  (OBJ_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
